// ----- rtl/assert_macros.svh -----
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cu_pkg.sv -----
// shared widths and defaults for the combination unrank unit
package cu_pkg;
  localparam int SIZE_W      = 5;
  localparam int RANK_W      = 16;
  localparam int POS_W       = 4;
  localparam int POS_LIMIT   = 16;
  localparam int MAX_SET_DEF = 16;
endpackage

// ----- rtl/cu_in_if.sv -----
// request channel: set size, subset size and rank
interface cu_in_if;
  logic                       valid;
  logic                       ready;
  logic [cu_pkg::SIZE_W-1:0]  set_size;
  logic [cu_pkg::SIZE_W-1:0]  subset_size;
  logic [cu_pkg::RANK_W-1:0]  rank;

  modport source (output valid, output set_size, output subset_size, output rank,
                  input ready);
  modport sink   (input valid, input set_size, input subset_size, input rank,
                  output ready);
endinterface

// ----- rtl/cu_out_if.sv -----
// result channel: one chosen position per word
interface cu_out_if;
  logic                      valid;
  logic                      ready;
  logic [cu_pkg::POS_W-1:0]  position;
  logic                      last;
  logic                      bad_rank;

  modport source (output valid, output position, output last, output bad_rank,
                  input ready);
  modport sink   (input valid, input position, input last, input bad_rank,
                  output ready);
endinterface

// ----- rtl/combination_unrank_unit.sv -----
// combination unrank unit: rank of a k-subset of n elements to its ascending positions
//
// After reset the unit builds a binomial table C(a,b), a and b up to N = min(MAX_SET,16),
// each entry with a read state and a write state, and in_chan.ready stays low until the
// table is built. A request is then taken while the unit is idle. When k >= n it sends
// positions 0..n-1, one word per cycle unless out_chan stalls; k = 0 or n = 0 gives no word.
// Otherwise it does the range check against C(n,k) in S_CHK_RD and S_CHK, then visits at
// most n candidate positions, each in S_STEP_RD and S_STEP, and out_chan can stall it.
// The read and compare states come from the table's one registered read port: each
// candidate is a read of C(n-1-v,k-1-j) followed by a compare-subtract against the
// remaining rank. A rank of C(n,k) or more gives one word with bad_rank and last set. The
// next request is accepted while the last word still waits in the output register.
`include "assert_macros.svh"

module combination_unrank_unit #(
  parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cu_in_if.sink    in_chan,
  cu_out_if.source out_chan
);
  localparam int NEFF  = (MAX_SET < cu_pkg::POS_LIMIT) ? MAX_SET : cu_pkg::POS_LIMIT;
  localparam int AW    = $clog2(NEFF + 1);
  localparam int DEPTH = 1 << (2 * AW);
  localparam int CW    = cu_pkg::RANK_W;

  typedef enum logic [2:0] {
    S_FILL_RD, S_FILL_WR, S_IDLE, S_ALL, S_CHK_RD, S_CHK, S_STEP_RD, S_STEP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [AW-1:0]             fa_r, fa_nxt, fb_r, fb_nxt;
  logic [CW-1:0]             left_r, left_nxt;
  logic [AW-1:0]             n_r, n_nxt, k_r, k_nxt, v_r, v_nxt, j_r, j_nxt;
  logic [CW-1:0]             rem_r, rem_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [cu_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_bad_r, out_bad_nxt;

  logic                      we;
  logic [2*AW-1:0]           waddr, raddr;
  logic [CW-1:0]             wdata, rdata;
  logic                      emit_ok;
  logic [cu_pkg::SIZE_W-1:0] n_clamp;
  logic [AW-1:0]             step_a, step_b;

  cu_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_chan.ready     = (state_r == S_IDLE);
  assign out_chan.valid    = out_valid_r;
  assign out_chan.position = out_pos_r;
  assign out_chan.last     = out_last_r;
  assign out_chan.bad_rank = out_bad_r;

  assign emit_ok = !out_valid_r || out_chan.ready;
  assign n_clamp = (in_chan.set_size > cu_pkg::SIZE_W'(NEFF)) ?
                   cu_pkg::SIZE_W'(NEFF) : in_chan.set_size;
  assign step_a  = n_r - AW'(1) - v_r;
  assign step_b  = k_r - AW'(1) - j_r;

  always_comb begin
    state_nxt     = state_r;
    fa_nxt        = fa_r;
    fb_nxt        = fb_r;
    left_nxt      = left_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    v_nxt         = v_r;
    j_nxt         = j_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    we            = 1'b0;
    waddr         = {fa_r, fb_r};
    wdata         = '0;
    raddr         = {step_a, step_b};

    unique case (state_r)
      S_FILL_RD: begin
        raddr     = {fa_r - AW'(1), fb_r};
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        // pascal rule: C(a,b) = C(a-1,b-1) + C(a-1,b)
        we = 1'b1;
        if (fb_r == '0) begin
          wdata = CW'(1);
        end else if (fa_r == '0) begin
          wdata = '0;
        end else begin
          wdata = left_r + rdata;
        end
        left_nxt  = (fa_r == '0) ? '0 : rdata;
        state_nxt = S_FILL_RD;
        if (fb_r == AW'(NEFF)) begin
          fb_nxt = '0;
          if (fa_r == AW'(NEFF)) begin
            state_nxt = S_IDLE;
          end else begin
            fa_nxt = fa_r + AW'(1);
          end
        end else begin
          fb_nxt = fb_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (in_chan.valid) begin
          n_nxt   = AW'(n_clamp);
          k_nxt   = AW'(in_chan.subset_size);
          rem_nxt = in_chan.rank;
          v_nxt   = '0;
          j_nxt   = '0;
          if (in_chan.subset_size >= n_clamp) begin
            state_nxt = (n_clamp == '0) ? S_IDLE : S_ALL;
          end else if (in_chan.subset_size == '0) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CHK_RD;
          end
        end
      end
      S_ALL: begin
        if (emit_ok) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cu_pkg::POS_W'(v_r);
          out_last_nxt  = (v_r == n_r - AW'(1));
          out_bad_nxt   = 1'b0;
          v_nxt         = v_r + AW'(1);
          if (v_r == n_r - AW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_CHK_RD: begin
        raddr     = {n_r, k_r};
        state_nxt = S_CHK;
      end
      S_CHK: begin
        raddr = {n_r, k_r};
        if (rem_r >= rdata) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            out_bad_nxt   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_STEP_RD;
        end
      end
      S_STEP_RD: begin
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (rem_r < rdata) begin
          if (emit_ok) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = cu_pkg::POS_W'(v_r);
            out_last_nxt  = (j_r == k_r - AW'(1));
            out_bad_nxt   = 1'b0;
            v_nxt         = v_r + AW'(1);
            j_nxt         = j_r + AW'(1);
            state_nxt     = (j_r == k_r - AW'(1)) ? S_IDLE : S_STEP_RD;
          end
        end else begin
          rem_nxt   = rem_r - rdata;
          v_nxt     = v_r + AW'(1);
          state_nxt = S_STEP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL_RD;
      fa_r        <= '0;
      fb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
      out_valid_r <= out_valid_nxt;
    end
    left_r     <= left_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    v_r        <= v_nxt;
    j_r        <= j_nxt;
    rem_r      <= rem_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  `CU_ASSERT_IMP(a_bad_is_last, out_valid_r && out_bad_r, out_last_r, "bad rank word without last")
  `CU_ASSERT_IMP(a_walk_in_range, state_r == S_STEP, (v_r < n_r) && (j_r < k_r), "walk past set")
  `CU_ASSERT_NXT(a_no_refill, state_r == S_IDLE,
                 (state_r != S_FILL_RD) && (state_r != S_FILL_WR), "table fill restarted")

endmodule

// ----- rtl/cu_ram.sv -----
// generic single-write, single-read ram with registered read data
module cu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
